// File: rtl/ldcs_pkg.sv
package ldcs_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ACTIVE_W   = 11;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned OP_W       = 3;

  localparam logic [ACTIVE_W-1:0] ACTIVE_W_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_DEPOSIT = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_MERGE   = 3'd2,
    OP_SWAP    = 3'd3,
    OP_READOUT = 3'd4
  } op_e;

  typedef logic signed [DATA_W-1:0] charge_t;

endpackage

// File: rtl/ldcs_sat_add.sv
module ldcs_sat_add
  import ldcs_pkg::*;
(
  input  charge_t a_i,
  input  charge_t b_i,
  output charge_t sum_o
);

  logic [DATA_W:0] wide;

  assign wide = {a_i[DATA_W-1], a_i} + {b_i[DATA_W-1], b_i};

  // top two bits disagree on overflow, the carry-out gives the direction
  always_comb begin
    if (wide[DATA_W] != wide[DATA_W-1]) begin
      sum_o = wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_o = wide[DATA_W-1:0];
    end
  end

endmodule

// File: rtl/ldcs_pixel_mem.sv
module ldcs_pixel_mem
  import ldcs_pkg::*;
#(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  charge_t           wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output charge_t           rdata_a_o,
  output charge_t           rdata_b_o
);

  charge_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: rtl/detector_line_charge_store.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o  | operation_i line_a_i line_b_i column_i energy_i
// out     | output    | out_valid_o/out_ready_i| found_o column_out_o charge_out_o
// cfg     | input     | cfg_we_i (no wait)     | cfg_wdata_i (active width)
//
// after reset a zeroing sweep over all NUM_LINES * 2**ceil(log2(MAX_WIDTH)) words (2048 by
// default) of the pixel memory runs before the first item is taken.
// swap, unused codes, an out-of-width deposit and a clear or readout of a line without charge
// go straight to the result; deposit reads and then writes its pixel, clear zeroes all MAX_WIDTH
// pixels of the line, merge and readout sweep the active width one pixel per cycle, readout
// stopping at the first pixel found; a result left unaccepted holds the next item back
module detector_line_charge_store
  import ldcs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned NUM_LINES = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic                line_a_i,
  input  logic                line_b_i,
  input  logic [COL_W-1:0]    column_i,
  input  logic signed [DATA_W-1:0] energy_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [COL_W-1:0]    column_out_o,
  output logic signed [DATA_W-1:0] charge_out_o,
  input  logic                cfg_we_i,
  input  logic [ACTIVE_W-1:0] cfg_wdata_i
);

  localparam int unsigned ColW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CntW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpW   = (CntW > ACTIVE_W) ? CntW : ACTIVE_W;
  localparam int unsigned LineW  = $clog2(NUM_LINES);
  localparam int unsigned AddrW  = LineW + ColW;
  localparam int unsigned Depth  = NUM_LINES * (2 ** ColW);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CmpW-1:0]  LastCol  = CmpW'(MAX_WIDTH - 1);
  localparam logic [CmpW-1:0]  MaxW     = CmpW'(MAX_WIDTH);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DEP_RD = 3'd2;
  localparam logic [2:0] ST_DEP_WR = 3'd3;
  localparam logic [2:0] ST_CLR    = 3'd4;
  localparam logic [2:0] ST_MRG    = 3'd5;
  localparam logic [2:0] ST_RDO    = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [ACTIVE_W-1:0] aw_q;
  logic [LineW-1:0]    map_q [NUM_LINES];
  logic [LineW-1:0]    map_d [NUM_LINES];
  logic [NUM_LINES-1:0] has_q, has_d;
  logic [AddrW-1:0]    init_q, init_d;
  logic [LineW-1:0]    pa_q, pa_d, pb_q, pb_d;
  logic [CmpW-1:0]     idx_q, idx_d, s1_idx_q, s1_idx_d;
  logic                s1_v_q, s1_v_d;
  charge_t             energy_q, energy_d;
  logic                res_found_q, res_found_d;
  logic [COL_W-1:0]    res_col_q, res_col_d;
  charge_t             res_charge_q, res_charge_d;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q;
  logic [COL_W-1:0]    out_col_q;
  charge_t             out_charge_q;

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  charge_t             mem_wdata;
  charge_t             rd_a, rd_b;
  charge_t             add_b, add_sum;

  logic [CmpW-1:0]     eff_w, aw_ext, col_ext;
  logic [LineW-1:0]    ia, ib, pa_in, pb_in;
  logic                issue, hit, out_load;

  ldcs_pixel_mem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i ({pa_q, idx_q[ColW-1:0]}),
    .raddr_b_i ({pb_q, idx_q[ColW-1:0]}),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign add_b = (state_q == ST_DEP_WR) ? energy_q : rd_b;

  ldcs_sat_add u_add (
    .a_i   (rd_a),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  assign aw_ext  = CmpW'(aw_q);
  assign eff_w   = (aw_ext > MaxW) ? MaxW : aw_ext;
  assign col_ext = CmpW'(column_i);
  assign ia      = LineW'(line_a_i);
  assign ib      = LineW'(line_b_i);
  assign pa_in   = map_q[ia];
  assign pb_in   = map_q[ib];
  assign issue   = idx_q < eff_w;
  assign hit     = s1_v_q && (rd_a > 0);
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign column_out_o = out_col_q;
  assign charge_out_o = out_charge_q;

  always_comb begin
    state_d      = state_q;
    map_d        = map_q;
    has_d        = has_q;
    init_d       = init_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    idx_d        = idx_q;
    s1_idx_d     = s1_idx_q;
    s1_v_d       = s1_v_q;
    energy_d     = energy_q;
    res_found_d  = res_found_q;
    res_col_d    = res_col_q;
    res_charge_d = res_charge_q;
    mem_we       = 1'b0;
    mem_waddr    = {pa_q, s1_idx_q[ColW-1:0]};
    mem_wdata    = '0;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        init_d    = init_q + 1'b1;
        if (init_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          pa_d         = pa_in;
          pb_d         = pb_in;
          energy_d     = energy_i;
          idx_d        = col_ext;
          s1_v_d       = 1'b0;
          res_found_d  = 1'b0;
          res_col_d    = '0;
          res_charge_d = '0;
          state_d      = ST_FIN;
          unique case (op_e'(operation_i))
            OP_DEPOSIT: begin
              if (col_ext < eff_w) begin
                state_d = ST_DEP_RD;
              end
            end
            OP_CLEAR: begin
              // a line without the flag is already all zero
              if (has_q[pa_in]) begin
                idx_d   = '0;
                state_d = ST_CLR;
              end
            end
            OP_MERGE: begin
              has_d[pa_in] = has_q[pa_in] | has_q[pb_in];
              idx_d        = '0;
              state_d      = ST_MRG;
            end
            OP_SWAP: begin
              map_d[ia] = map_q[ib];
              map_d[ib] = map_q[ia];
            end
            OP_READOUT: begin
              if (has_q[pa_in]) begin
                idx_d   = '0;
                state_d = ST_RDO;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DEP_RD: begin
        state_d = ST_DEP_WR;
      end
      ST_DEP_WR: begin
        mem_we       = 1'b1;
        mem_waddr    = {pa_q, idx_q[ColW-1:0]};
        mem_wdata    = add_sum;
        has_d[pa_q]  = 1'b1;
        state_d      = ST_FIN;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {pa_q, idx_q[ColW-1:0]};
        idx_d     = idx_q + 1'b1;
        if (idx_q == LastCol) begin
          has_d[pa_q] = 1'b0;
          state_d     = ST_FIN;
        end
      end
      ST_MRG: begin
        // read of pixel i overlaps the write-back of pixel i-1
        s1_v_d   = issue;
        s1_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (s1_v_q) begin
          mem_we    = 1'b1;
          mem_wdata = add_sum;
        end
        if (!issue && !s1_v_q) begin
          state_d = ST_FIN;
        end
      end
      ST_RDO: begin
        if (hit) begin
          mem_we       = 1'b1;
          res_found_d  = 1'b1;
          res_col_d    = s1_idx_q[COL_W-1:0];
          res_charge_d = rd_a;
          s1_v_d       = 1'b0;
          state_d      = ST_FIN;
        end else begin
          s1_v_d   = issue;
          s1_idx_d = idx_q;
          if (issue) begin
            idx_d = idx_q + 1'b1;
          end
          if (!issue && !s1_v_q) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      aw_q        <= ACTIVE_W_RST;
      has_q       <= '0;
      init_q      <= '0;
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        map_q[i] <= LineW'(i);
      end
    end else begin
      state_q     <= state_d;
      has_q       <= has_d;
      init_q      <= init_d;
      s1_v_q      <= s1_v_d;
      out_valid_q <= out_valid_d;
      map_q       <= map_d;
      if (cfg_we_i) begin
        aw_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    idx_q        <= idx_d;
    s1_idx_q     <= s1_idx_d;
    energy_q     <= energy_d;
    res_found_q  <= res_found_d;
    res_col_q    <= res_col_d;
    res_charge_q <= res_charge_d;
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_col_q    <= res_col_q;
      out_charge_q <= res_charge_q;
    end
  end

endmodule

// File: verif/line_charge_checker.sv
`timescale 1ns / 1ps

module line_charge_checker
  import ldcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic                line_a_i,
  input  logic                line_b_i,
  input  logic [COL_W-1:0]    column_i,
  input  charge_t             energy_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                found_i,
  input  logic [COL_W-1:0]    column_out_i,
  input  charge_t             charge_out_i,
  input  logic                cfg_we_i,
  input  logic [ACTIVE_W-1:0] cfg_wdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned NUM_LINES = 2;

  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] column;
    charge_t          charge;
  } readout_t;

  charge_t             pixel_q [NUM_LINES][MAX_WIDTH];
  logic                line_charged_q [NUM_LINES];
  logic                line_map_q [NUM_LINES];
  logic [ACTIVE_W-1:0] active_width_q;
  readout_t            expected_readouts [$];
  int unsigned         results_seen;

  task automatic report_mismatch(input string msg);
    $display("error: result %0d: %s", results_seen, msg);
    fail_count_o++;
  endtask

  function automatic charge_t sat_add(charge_t x, charge_t y);
    logic signed [DATA_W:0] sum;
    sum = {x[DATA_W-1], x} + {y[DATA_W-1], y};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      return sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return sum[DATA_W-1:0];
  endfunction

  // updates the store and returns what the item should produce
  function automatic readout_t apply_line_op(logic [OP_W-1:0] op, logic a, logic b,
                                             logic [COL_W-1:0] col, charge_t energy);
    readout_t    res;
    int unsigned pa;
    int unsigned pb;
    int unsigned w;
    logic        tmp;
    res = '0;
    pa  = 32'(line_map_q[a]);
    pb  = 32'(line_map_q[b]);
    w   = (active_width_q > MAX_WIDTH) ? MAX_WIDTH : 32'(active_width_q);
    case (op)
      OP_DEPOSIT: begin
        if (col < w) begin
          pixel_q[pa][col]   = sat_add(pixel_q[pa][col], energy);
          line_charged_q[pa] = 1'b1;
        end
      end
      OP_CLEAR: begin
        // whole line, independent of the active width
        if (line_charged_q[pa]) begin
          for (int i = 0; i < MAX_WIDTH; i++) pixel_q[pa][i] = '0;
          line_charged_q[pa] = 1'b0;
        end
      end
      OP_MERGE: begin
        for (int i = 0; i < w; i++) pixel_q[pa][i] = sat_add(pixel_q[pa][i], pixel_q[pb][i]);
        line_charged_q[pa] = line_charged_q[pa] | line_charged_q[pb];
      end
      OP_SWAP: begin
        tmp           = line_map_q[a];
        line_map_q[a] = line_map_q[b];
        line_map_q[b] = tmp;
      end
      OP_READOUT: begin
        if (line_charged_q[pa]) begin
          for (int i = 0; i < w; i++) begin
            if (pixel_q[pa][i] > 0) begin
              res.found     = 1'b1;
              res.column    = i[COL_W-1:0];
              res.charge    = pixel_q[pa][i];
              pixel_q[pa][i] = '0;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    readout_t got;
    readout_t want;
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LINES; l++) begin
        for (int i = 0; i < MAX_WIDTH; i++) pixel_q[l][i] = '0;
        line_charged_q[l] = 1'b0;
        line_map_q[l]     = l[0];
      end
      active_width_q = ACTIVE_W_RST;
      expected_readouts.delete();
      pending_o    = 0;
      fail_count_o = 0;
      results_seen = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{found_i, column_out_i, charge_out_i};
        if (expected_readouts.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b column=%0d charge=%h",
                                    got.found, got.column, got.charge));
        end else begin
          want = expected_readouts.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
          if (got.column !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d", got.column, want.column));
          if (got.charge !== want.charge)
            report_mismatch($sformatf("charge %h, expected %h", got.charge, want.charge));
        end
        results_seen++;
      end
      if (cfg_we_i) active_width_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        expected_readouts.push_back(apply_line_op(operation_i, line_a_i, line_b_i,
                                                  column_i, energy_i));
      end
      pending_o = expected_readouts.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ldcs_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam charge_t CHARGE_MAX = 32'sh7fff_ffff;
  localparam charge_t CHARGE_MIN = 32'sh8000_0000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     operation;
  logic                line_a;
  logic                line_b;
  logic [COL_W-1:0]    column;
  charge_t             energy;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic [COL_W-1:0]    column_out;
  charge_t             charge_out;
  logic                cfg_we;
  logic [ACTIVE_W-1:0] cfg_wdata;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         width_now = 1024;
  logic                no_idle = 1'b0;

  always #5 clk = ~clk;

  detector_line_charge_store i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (operation),
    .line_a_i     (line_a),
    .line_b_i     (line_b),
    .column_i     (column),
    .energy_i     (energy),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .column_out_o (column_out),
    .charge_out_o (charge_out),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  line_charge_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .operation_i  (operation),
    .line_a_i     (line_a),
    .line_b_i     (line_b),
    .column_i     (column),
    .energy_i     (energy),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .found_i      (found),
    .column_out_i (column_out),
    .charge_out_i (charge_out),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [OP_W-1:0] op, logic a, logic b, logic [COL_W-1:0] col,
                           charge_t en);
    in_valid  <= 1'b1;
    operation <= op;
    line_a    <= a;
    line_b    <= b;
    column    <= col;
    energy    <= en;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_width(logic [ACTIVE_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    width_now = 32'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned      pick;
    int unsigned      w;
    logic [OP_W-1:0]  op;
    logic [COL_W-1:0] col;
    charge_t          en;
    w = (width_now > 1024) ? 1024 : width_now;
    repeat (count) begin
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      if (!no_idle && $urandom_range(0, 49) == 0) drain();
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_DEPOSIT;
      else if (pick < 70) op = OP_READOUT;
      else if (pick < 80) op = OP_MERGE;
      else if (pick < 88) op = OP_SWAP;
      else if (pick < 95) op = OP_CLEAR;
      else                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      // mostly inside the active width so deposits land and readouts find them
      if (w > 0 && $urandom_range(0, 9) != 0) col = COL_W'($urandom_range(0, w - 1));
      else                                    col = COL_W'($urandom);
      case ($urandom_range(0, 5))
        0, 1:    en = $urandom_range(1, 32'h0004_0000);
        2:       en = -$signed({1'b0, 31'($urandom_range(1, 32'h0004_0000))});
        3:       en = $urandom;
        4:       en = $urandom_range(0, 1) ? CHARGE_MAX : CHARGE_MIN;
        default: en = '0;
      endcase
      send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), col, en);
    end
  endtask

  // receiver back-pressure in bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      out_ready <= no_idle || stall_left == 0;
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL detector_line_charge_store");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    operation = OP_DEPOSIT;
    line_a    = 1'b0;
    line_b    = 1'b0;
    column    = '0;
    energy    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // saturation at both ends, zero energy, readout of non-positive pixels
    send_item(OP_DEPOSIT, 1'b0, 1'b0, 10'd0, CHARGE_MAX);
    send_item(OP_DEPOSIT, 1'b0, 1'b1, 10'd0, 32'sd1);
    send_item(OP_DEPOSIT, 1'b0, 1'b0, 10'd1023, CHARGE_MIN);
    send_item(OP_DEPOSIT, 1'b0, 1'b0, 10'd1023, -32'sd1);
    send_item(OP_DEPOSIT, 1'b1, 1'b0, 10'd5, '0);
    send_item(OP_READOUT, 1'b1, 1'b0, 10'd0, '0);
    send_item(OP_READOUT, 1'b0, 1'b0, 10'd0, '0);
    send_item(OP_READOUT, 1'b0, 1'b0, 10'd0, '0);
    send_item(OP_DEPOSIT, 1'b1, 1'b0, 10'd3, 32'sh0001_8000);
    send_item(OP_MERGE,   1'b0, 1'b1, 10'd0, '0);
    // merge into itself doubles
    send_item(OP_MERGE,   1'b0, 1'b0, 10'd0, '0);
    send_item(OP_SWAP,    1'b0, 1'b1, 10'd0, '0);
    send_item(OP_SWAP,    1'b1, 1'b1, 10'd0, '0);
    send_item(OP_READOUT, 1'b1, 1'b0, 10'd0, '0);
    send_item(OP_READOUT, 1'b0, 1'b0, 10'd0, '0);
    send_item(OP_CLEAR,   1'b1, 1'b0, 10'd0, '0);
    send_item(OP_CLEAR,   1'b1, 1'b0, 10'd0, '0);
    send_item(OP_READOUT, 1'b1, 1'b0, 10'd0, '0);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      send_item(c[OP_W-1:0], 1'b1, 1'b1, 10'h3ff, CHARGE_MIN);

    // zero width: deposit ignored, merge and readout touch nothing, clear still works
    write_width('0);
    send_item(OP_DEPOSIT, 1'b0, 1'b0, 10'd0, 32'sd100);
    send_item(OP_MERGE,   1'b0, 1'b1, 10'd0, '0);
    send_item(OP_READOUT, 1'b0, 1'b0, 10'd0, '0);
    send_item(OP_CLEAR,   1'b0, 1'b0, 10'd0, '0);

    // width beyond the line length behaves as the full line
    write_width('1);
    send_item(OP_DEPOSIT, 1'b1, 1'b0, 10'd1023, 32'sd5);
    send_item(OP_READOUT, 1'b1, 1'b0, 10'd0, '0);
    send_item(OP_MERGE,   1'b0, 1'b1, 10'd0, '0);

    write_width(11'd1);
    run_random(80);
    repeat (3) begin
      write_width(ACTIVE_W'($urandom_range(2, 32)));
      run_random(100);
    end
    write_width(ACTIVE_W_RST);
    run_random(40);

    write_width(ACTIVE_W'($urandom_range(1, 16)));
    no_idle = 1'b1;
    run_random(125);

    drain();
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS detector_line_charge_store");
    end else begin
      $display("FAIL detector_line_charge_store");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ldcs_pkg.sv
rtl/ldcs_sat_add.sv
rtl/ldcs_pixel_mem.sv
rtl/detector_line_charge_store.sv
verif/line_charge_checker.sv
verif/tb_top.sv
